// ===== sv/rtb_pkg.sv =====
// shared types, constants and modular helpers for the radix-3 ntt butterfly
package rtb_pkg;

  localparam int RESIDUE_WIDTH = 62;
  localparam int ADDR_WIDTH    = 5;
  localparam int DATA_WIDTH    = 64;
  // total pipeline depth: reduction, two add stages, multiply, two add stages, twiddle
  localparam int PIPE_DEPTH    = 3 * RESIDUE_WIDTH + 4;

  typedef logic [RESIDUE_WIDTH-1:0] residue_t;

  // register indexes
  localparam logic [1:0] REG_MODULUS            = 2'd0;
  localparam logic [1:0] REG_FIRST_COEFFICIENT  = 2'd1;
  localparam logic [1:0] REG_SECOND_COEFFICIENT = 2'd2;

  typedef struct packed {
    logic     command;
    residue_t sample_zero;
    residue_t sample_one;
    residue_t sample_two;
    residue_t twiddle_one;
    residue_t twiddle_two;
  } request_t;

  typedef struct packed {
    residue_t result_zero;
    residue_t result_one;
    residue_t result_two;
  } result_t;

  // a + b mod p, operands below p
  function automatic residue_t add_mod(residue_t a, residue_t b, residue_t p);
    logic [RESIDUE_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, p}) begin
      sum = sum - {1'b0, p};
    end
    return sum[RESIDUE_WIDTH-1:0];
  endfunction

  // a - b mod p, operands below p
  function automatic residue_t sub_mod(residue_t a, residue_t b, residue_t p);
    residue_t diff;
    if (a >= b) begin
      diff = a - b;
    end else begin
      diff = a + (p - b);
    end
    return diff;
  endfunction

endpackage

// ===== sv/rtb_reduce.sv =====
// pipelined restoring reduction of one residue mod p, one bit per stage
module rtb_reduce (
  input  logic              clk,
  input  logic              en,
  input  rtb_pkg::residue_t modulus,
  input  rtb_pkg::residue_t value,
  output rtb_pkg::residue_t remainder
);
  import rtb_pkg::*;

  residue_t acc [RESIDUE_WIDTH];
  residue_t bits [RESIDUE_WIDTH-1];

  for (genvar k = 0; k < RESIDUE_WIDTH; k++) begin : g_stage
    residue_t               acc_in;
    residue_t               bits_in;
    logic [RESIDUE_WIDTH:0] trial;
    logic [RESIDUE_WIDTH:0] trial_sub;

    if (k == 0) begin : g_first
      assign acc_in  = '0;
      assign bits_in = value;
    end else begin : g_rest
      assign acc_in  = acc[k-1];
      assign bits_in = bits[k-1];
    end

    // shift in the next bit and subtract p once
    assign trial     = {acc_in, bits_in[RESIDUE_WIDTH-1-k]};
    assign trial_sub = trial - {1'b0, modulus};

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= (trial >= {1'b0, modulus}) ? trial_sub[RESIDUE_WIDTH-1:0]
                                             : trial[RESIDUE_WIDTH-1:0];
      end
    end

    if (k < RESIDUE_WIDTH - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          bits[k] <= bits_in;
        end
      end
    end
  end

  assign remainder = acc[RESIDUE_WIDTH-1];

endmodule

// ===== sv/rtb_mulmod.sv =====
// pipelined shift-and-add modular multiplier, one multiplier bit per stage
module rtb_mulmod (
  input  logic              clk,
  input  logic              en,
  input  rtb_pkg::residue_t modulus,
  input  rtb_pkg::residue_t multiplicand,
  input  rtb_pkg::residue_t multiplier,
  output rtb_pkg::residue_t product
);
  import rtb_pkg::*;

  residue_t acc [RESIDUE_WIDTH];
  residue_t mcand [RESIDUE_WIDTH-1];
  residue_t mplier [RESIDUE_WIDTH-1];

  for (genvar k = 0; k < RESIDUE_WIDTH; k++) begin : g_stage
    residue_t acc_in;
    residue_t mcand_in;
    residue_t mplier_in;
    residue_t dbl;

    if (k == 0) begin : g_first
      assign acc_in    = '0;
      assign mcand_in  = multiplicand;
      assign mplier_in = multiplier;
    end else begin : g_rest
      assign acc_in    = acc[k-1];
      assign mcand_in  = mcand[k-1];
      assign mplier_in = mplier[k-1];
    end

    // double, then add the multiplicand when this bit is set
    assign dbl = add_mod(acc_in, acc_in, modulus);

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= mplier_in[RESIDUE_WIDTH-1-k] ? add_mod(dbl, mcand_in, modulus) : dbl;
      end
    end

    if (k < RESIDUE_WIDTH - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          mcand[k]  <= mcand_in;
          mplier[k] <= mplier_in;
        end
      end
    end
  end

  assign product = acc[RESIDUE_WIDTH-1];

endmodule

// ===== sv/radix3_ntt_butterfly.sv =====
// radix-3 ntt butterfly top level: pipeline and two-entry result buffer
// throughput: one request per cycle while the result buffer has a free entry;
// input reduction, the coefficient multiply and the twiddle multiply are each
// RESIDUE_WIDTH bit-serial stages deep
// the pipeline stalls only when both result buffer entries are full
// reset (rst, synchronous) clears valid bits and empties the buffer; modulus=3, coefficients=0
module radix3_ntt_butterfly (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                request_valid,
  output logic                                request_ready,
  input  rtb_pkg::request_t                   request,
  output logic                                result_valid,
  input  logic                                result_ready,
  output rtb_pkg::result_t                    result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtb_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [rtb_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [rtb_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready
);
  import rtb_pkg::*;

  residue_t modulus;
  residue_t first_coefficient;
  residue_t second_coefficient;
  logic [1:0] reg_index;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_WIDTH-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus            <= residue_t'(3);
      first_coefficient  <= '0;
      second_coefficient <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_MODULUS:            modulus            <= pwdata[RESIDUE_WIDTH-1:0];
        REG_FIRST_COEFFICIENT:  first_coefficient  <= pwdata[RESIDUE_WIDTH-1:0];
        REG_SECOND_COEFFICIENT: second_coefficient <= pwdata[RESIDUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_index)
      REG_MODULUS:            prdata = DATA_WIDTH'(modulus);
      REG_FIRST_COEFFICIENT:  prdata = DATA_WIDTH'(first_coefficient);
      REG_SECOND_COEFFICIENT: prdata = DATA_WIDTH'(second_coefficient);
      default:                prdata = '0;
    endcase
  end

  logic [1:0]            count;
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] cmd;

  // pipeline advances whenever the result buffer has a free entry
  assign en            = (count != 2'd2);
  assign request_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], request_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= {cmd[PIPE_DEPTH-2:0], request.command};
    end
  end

  // input reduction
  residue_t x0_r, x1_r, x2_r, w1_r, w2_r, c1_r, c2_r;

  rtb_reduce u_red_x0 (.clk, .en, .modulus, .value(request.sample_zero), .remainder(x0_r));
  rtb_reduce u_red_x1 (.clk, .en, .modulus, .value(request.sample_one),  .remainder(x1_r));
  rtb_reduce u_red_x2 (.clk, .en, .modulus, .value(request.sample_two),  .remainder(x2_r));
  rtb_reduce u_red_w1 (.clk, .en, .modulus, .value(request.twiddle_one), .remainder(w1_r));
  rtb_reduce u_red_w2 (.clk, .en, .modulus, .value(request.twiddle_two), .remainder(w2_r));
  rtb_reduce u_red_c1 (.clk, .en, .modulus, .value(first_coefficient),   .remainder(c1_r));
  rtb_reduce u_red_c2 (.clk, .en, .modulus, .value(second_coefficient),  .remainder(c2_r));

  // sum and difference, then y0
  residue_t a_a, b_a, x0_a, w1_a, w2_a, c1_a, c2_a;
  residue_t y0_b, a_b, b_b, w1_b, w2_b, c1_b, c2_b;

  always_ff @(posedge clk) begin
    if (en) begin
      a_a  <= add_mod(x1_r, x2_r, modulus);
      b_a  <= sub_mod(x1_r, x2_r, modulus);
      x0_a <= x0_r;
      w1_a <= w1_r;
      w2_a <= w2_r;
      c1_a <= c1_r;
      c2_a <= c2_r;
      y0_b <= add_mod(x0_a, a_a, modulus);
      a_b  <= a_a;
      b_b  <= b_a;
      w1_b <= w1_a;
      w2_b <= w2_a;
      c1_b <= c1_a;
      c2_b <= c2_a;
    end
  end

  // coefficient products
  residue_t m1, m2;
  residue_t y0_d [RESIDUE_WIDTH];
  residue_t w1_d [RESIDUE_WIDTH];
  residue_t w2_d [RESIDUE_WIDTH];

  rtb_mulmod u_mul_c1 (.clk, .en, .modulus, .multiplicand(a_b), .multiplier(c1_b),
                       .product(m1));
  rtb_mulmod u_mul_c2 (.clk, .en, .modulus, .multiplicand(b_b), .multiplier(c2_b),
                       .product(m2));

  always_ff @(posedge clk) begin
    if (en) begin
      y0_d[0] <= y0_b;
      w1_d[0] <= w1_b;
      w2_d[0] <= w2_b;
      for (int i = 1; i < RESIDUE_WIDTH; i++) begin
        y0_d[i] <= y0_d[i-1];
        w1_d[i] <= w1_d[i-1];
        w2_d[i] <= w2_d[i-1];
      end
    end
  end

  // s, then y1 and y2
  residue_t s_s, m2_s, y0_s, w1_s, w2_s;
  residue_t y1_y, y2_y, y0_y, w1_y, w2_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s_s  <= add_mod(y0_d[RESIDUE_WIDTH-1], m1, modulus);
      m2_s <= m2;
      y0_s <= y0_d[RESIDUE_WIDTH-1];
      w1_s <= w1_d[RESIDUE_WIDTH-1];
      w2_s <= w2_d[RESIDUE_WIDTH-1];
      y1_y <= add_mod(s_s, m2_s, modulus);
      y2_y <= sub_mod(s_s, m2_s, modulus);
      y0_y <= y0_s;
      w1_y <= w1_s;
      w2_y <= w2_s;
    end
  end

  // twiddle products, plain values delayed alongside
  residue_t t1, t2;
  residue_t y0_e [RESIDUE_WIDTH];
  residue_t y1_e [RESIDUE_WIDTH];
  residue_t y2_e [RESIDUE_WIDTH];

  rtb_mulmod u_mul_w1 (.clk, .en, .modulus, .multiplicand(y1_y), .multiplier(w1_y),
                       .product(t1));
  rtb_mulmod u_mul_w2 (.clk, .en, .modulus, .multiplicand(y2_y), .multiplier(w2_y),
                       .product(t2));

  always_ff @(posedge clk) begin
    if (en) begin
      y0_e[0] <= y0_y;
      y1_e[0] <= y1_y;
      y2_e[0] <= y2_y;
      for (int i = 1; i < RESIDUE_WIDTH; i++) begin
        y0_e[i] <= y0_e[i-1];
        y1_e[i] <= y1_e[i-1];
        y2_e[i] <= y2_e[i-1];
      end
    end
  end

  // final selection, zero modulus gives all zeros
  result_t fin;

  always_comb begin
    if (modulus == '0) begin
      fin = '0;
    end else begin
      fin.result_zero = y0_e[RESIDUE_WIDTH-1];
      fin.result_one  = cmd[PIPE_DEPTH-1] ? t1 : y1_e[RESIDUE_WIDTH-1];
      fin.result_two  = cmd[PIPE_DEPTH-1] ? t2 : y2_e[RESIDUE_WIDTH-1];
    end
  end

  // two-entry result buffer
  logic    push, pop;
  result_t ent0, ent1;

  assign push         = en && vld[PIPE_DEPTH-1];
  assign pop          = result_valid && result_ready;
  assign result_valid = (count != 2'd0);
  assign result       = ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: if (push) count <= 2'd1;
        2'd1: if (push && !pop) count <= 2'd2;
              else if (pop && !push) count <= 2'd0;
        default: if (pop) count <= 2'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) ent0 <= fin;
      2'd1: begin
        if (push && pop) ent0 <= fin;
        else if (push) ent1 <= fin;
      end
      default: if (pop) ent0 <= ent1;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");
  a_push_shows: assert property (@(posedge clk) disable iff (rst) push |=> result_valid)
    else $error("pushed result not visible");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
                                  (count == 2'd2) |-> !request_ready)
    else $error("request accepted with full result buffer");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench for the radix-3 ntt butterfly: directed table, random streams, apb setup
`timescale 1ns / 100ps

module testbench;
  import rtb_pkg::*;

  localparam logic CMD_PLAIN   = 1'b0;
  localparam logic CMD_TWIDDLE = 1'b1;
  localparam int   DRAIN_CYCLES = PIPE_DEPTH + 20;
  localparam int   LONG_HOLD    = 3 * PIPE_DEPTH;
  localparam int   CYCLE_LIMIT  = 600000;
  localparam int   NUM_PHASES   = 8;
  localparam logic [61:0] MAX62 = {62{1'b1}};
  localparam logic [61:0] BIG_PRIME = 62'd4611686018427387847;

  typedef struct {
    request_t rq;
    bit       typed;
    result_t  res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic request_valid;
  logic request_ready;
  request_t request;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;

  // configuration copy used for prediction
  residue_t cfg_modulus;
  residue_t cfg_coef_sum;
  residue_t cfg_coef_diff;

  result_t   butterfly_q[$];
  stim_row_t directed_rows[$];
  int error_count;
  int result_count;
  int twiddle_count;
  int cycle_count;
  int hold_requests;
  int burst_left;

  radix3_ntt_butterfly DUT (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_ready(request_ready), .request(request),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // modular product with a wide intermediate
  function automatic residue_t mul_residue(residue_t a, residue_t b, residue_t p);
    logic [127:0] prod;
    prod = ({66'd0, a} * {66'd0, b}) % {66'd0, p};
    return prod[61:0];
  endfunction

  // expected butterfly output for one request under the current configuration
  function automatic result_t butterfly_expected(request_t rq);
    result_t r;
    logic [63:0] p, x0, x1, x2, w1, w2, c1, c2, a, b, y0, s, m, y1, y2;
    r = '0;
    p = {2'b0, cfg_modulus};
    if (p == 0) return r;
    x0 = {2'b0, rq.sample_zero} % p;
    x1 = {2'b0, rq.sample_one} % p;
    x2 = {2'b0, rq.sample_two} % p;
    w1 = {2'b0, rq.twiddle_one} % p;
    w2 = {2'b0, rq.twiddle_two} % p;
    c1 = {2'b0, cfg_coef_sum} % p;
    c2 = {2'b0, cfg_coef_diff} % p;
    a  = (x1 + x2) % p;
    b  = (x1 + p - x2) % p;
    y0 = (x0 + a) % p;
    s  = (y0 + mul_residue(a[61:0], c1[61:0], p[61:0])) % p;
    m  = mul_residue(b[61:0], c2[61:0], p[61:0]);
    y1 = (s + m) % p;
    y2 = (s + p - m) % p;
    if (rq.command == CMD_TWIDDLE) begin
      y1 = mul_residue(y1[61:0], w1[61:0], p[61:0]);
      y2 = mul_residue(y2[61:0], w2[61:0], p[61:0]);
    end
    r.result_zero = y0[61:0];
    r.result_one  = y1[61:0];
    r.result_two  = y2[61:0];
    return r;
  endfunction

  function automatic residue_t rand_raw();
    return residue_t'({$urandom, $urandom});
  endfunction

  // mostly residues below the modulus, sometimes edges or unreduced values
  function automatic residue_t rand_residue();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return MAX62;
    if (pick == 2 && cfg_modulus != 0) return cfg_modulus - 1;
    if (pick == 3 || cfg_modulus == 0) return rand_raw();
    return rand_raw() % cfg_modulus;
  endfunction

  function automatic request_t rand_request();
    request_t rq;
    rq.command     = 1'($urandom_range(0, 1));
    rq.sample_zero = rand_residue();
    rq.sample_one  = rand_residue();
    rq.sample_two  = rand_residue();
    rq.twiddle_one = rand_residue();
    rq.twiddle_two = rand_residue();
    return rq;
  endfunction

  // apb register write, value kept in the predictor's copy
  task automatic reg_write(logic [1:0] index, residue_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_WIDTH'(index) << 3;
    pwdata  = {2'($urandom_range(0, 3)), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (index)
      REG_MODULUS:           cfg_modulus   = value;
      REG_FIRST_COEFFICIENT: cfg_coef_sum  = value;
      default:               cfg_coef_diff = value;
    endcase
  endtask

  // offer one request and record what it should produce
  task automatic send_request(request_t rq, bit typed, result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        request_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    request_valid = 1'b1;
    request = rq;
    do @(posedge clk); while (!request_ready);
    butterfly_q.push_back(typed ? res : butterfly_expected(rq));
    if (rq.command == CMD_TWIDDLE) twiddle_count++;
  endtask

  // sender stops until every outstanding result has come out
  task automatic drain_results();
    @(negedge clk);
    request_valid = 1'b0;
    while (butterfly_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stall pattern with an occasional long hold-off
  initial begin
    int seen_holds;
    int hold_left;
    int window;
    logic [7:0] pattern;
    seen_holds = 0;
    hold_left = 0;
    window = 0;
    pattern = 8'hff;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen_holds != hold_requests) begin
        seen_holds = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        pattern = $urandom_range(0, 2) == 0 ? 8'hff : 8'($urandom);
        if (pattern == 0) pattern = 8'h81;
      end
      window--;
      pattern = {pattern[6:0], pattern[7]};
      if (hold_left > 0) begin
        hold_left--;
        result_ready = 1'b0;
      end else begin
        result_ready = pattern[0];
      end
    end
  end

  // compare every delivered result with the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid && result_ready) begin
      result_count++;
      if (butterfly_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        exp_res = butterfly_q.pop_front();
        if (exp_res.result_zero !== result.result_zero) begin
          $display("%0t: result_zero expected %h actual %h", $time,
                   exp_res.result_zero, result.result_zero);
          error_count++;
        end
        if (exp_res.result_one !== result.result_one) begin
          $display("%0t: result_one expected %h actual %h", $time,
                   exp_res.result_one, result.result_one);
          error_count++;
        end
        if (exp_res.result_two !== result.result_two) begin
          $display("%0t: result_two expected %h actual %h", $time,
                   exp_res.result_two, result.result_two);
          error_count++;
        end
      end
    end
  end

  // directed rows: reset configuration, extremes of every field, both commands
  task automatic build_directed();
    stim_row_t row;
    row.typed = 1'b1;
    row.res = '0;
    row.rq = '0;
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, MAX62, MAX62, MAX62, MAX62, MAX62};
    directed_rows.push_back(row);
    row.rq = '{CMD_PLAIN, MAX62, MAX62, MAX62, MAX62, MAX62};
    directed_rows.push_back(row);
    row.rq = '{CMD_PLAIN, 62'd1, 62'd0, 62'd0, 62'd0, 62'd0};
    row.res = '{62'd1, 62'd1, 62'd1};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, 62'd1, 62'd0, 62'd0, 62'd2, 62'd0};
    row.res = '{62'd1, 62'd2, 62'd0};
    directed_rows.push_back(row);
    row.typed = 1'b0;
    row.rq = '{CMD_PLAIN, 62'd0, 62'd1, 62'd2, 62'd2, 62'd1};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, 62'd2, 62'd2, 62'd1, 62'd1, 62'd2};
    directed_rows.push_back(row);
    row.rq = '{CMD_PLAIN, 62'd0, MAX62, 62'd0, 62'd0, 62'd0};
    directed_rows.push_back(row);
    row.rq = '{CMD_PLAIN, 62'd0, 62'd0, MAX62, 62'd0, 62'd0};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, 62'd5, 62'd4, 62'd7, MAX62, 62'd1};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, BIG_PRIME - 1, BIG_PRIME - 1, 62'd0, BIG_PRIME - 1, BIG_PRIME};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, 62'd0, 62'd0, BIG_PRIME - 1, 62'd3, BIG_PRIME - 1};
    directed_rows.push_back(row);
    row.rq = '{CMD_PLAIN, BIG_PRIME, BIG_PRIME + 1, MAX62, 62'd0, 62'd0};
    directed_rows.push_back(row);
    row.rq = '{CMD_TWIDDLE, 62'h2aaaaaaaaaaaaaaa, 62'h1555555555555555,
               62'h2aaaaaaaaaaaaaaa, 62'h1555555555555555, 62'h2aaaaaaaaaaaaaaa};
    directed_rows.push_back(row);
  endtask

  // phase configurations: modulus, sum coefficient, difference coefficient
  task automatic set_phase(int phase);
    residue_t p, c1, c2;
    case (phase)
      1: begin p = BIG_PRIME; c1 = BIG_PRIME - 1; c2 = rand_raw() % BIG_PRIME; end
      2: begin p = '0; c1 = rand_raw(); c2 = rand_raw(); end
      3: begin p = 62'd1; c1 = 62'd5; c2 = MAX62; end
      4: begin p = MAX62; c1 = MAX62 - 1; c2 = MAX62; end
      5: begin p = 62'd65537; c1 = 62'd65535; c2 = rand_raw() % 62'd65537; end
      6: begin p = 62'd12; c1 = 62'd7; c2 = 62'd10; end
      default: begin p = 62'd97; c1 = 62'd1000; c2 = rand_raw(); end
    endcase
    reg_write(REG_MODULUS, p);
    reg_write(REG_FIRST_COEFFICIENT, c1);
    reg_write(REG_SECOND_COEFFICIENT, c2);
  endtask

  // main sequence
  initial begin
    int phase_items;
    rst = 1'b1;
    request_valid = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_modulus = 62'd3;
    cfg_coef_sum = '0;
    cfg_coef_diff = '0;
    error_count = 0;
    result_count = 0;
    twiddle_count = 0;
    hold_requests = 0;
    burst_left = 0;
    build_directed();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) set_phase(phase);
      if (phase <= 1) begin
        foreach (directed_rows[i])
          send_request(directed_rows[i].rq, directed_rows[i].typed && phase == 0,
                       directed_rows[i].res);
      end
      phase_items = (phase == 1 || phase == 4) ? 220 : 115;
      for (int n = 0; n < phase_items; n++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 1 && n == 20) hold_requests++;
        send_request(rand_request(), 1'b0, '0);
      end
      drain_results();
    end

    $display("tb: %0d results checked over %0d settings, %0d with twiddle", result_count,
             NUM_PHASES, twiddle_count);
    $display("tb: moduli covered include zero, one, even, small and large primes, 2^62-1");
    if (error_count == 0 && butterfly_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
